// ===== rtl/sieve_contact_force_macros.svh =====
// Assertion macros used by the checker file of the sieve contact force block.
`ifndef SIEVE_CONTACT_FORCE_MACROS_SVH
`define SIEVE_CONTACT_FORCE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SCF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SCF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scf_pkg.sv =====
// Shared types, constants and helper functions of the sieve contact force block.
package scf_pkg;

    localparam int NUM_PARTICLES = 65536;
    localparam int TAB_AW        = $clog2(NUM_PARTICLES);
    localparam int TRI_W         = 12;
    localparam int ST_W          = 2;
    localparam int ENT_W         = ST_W + TRI_W;
    localparam int QUO_W         = 57;
    localparam int DCNT_W        = 6;
    localparam int PADDR_W       = 6;

    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(QUO_W - 1);

    localparam logic [63:0] PIOVERFOUR = 64'd3373259426;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    localparam logic [ST_W-1:0] ST_FREE   = 2'd0;
    localparam logic [ST_W-1:0] ST_PASSED = 2'd1;
    localparam logic [ST_W-1:0] ST_HELD   = 2'd2;

    localparam logic [2:0] REG_SIZE      = 3'd0;
    localparam logic [2:0] REG_SPACING   = 3'd1;
    localparam logic [2:0] REG_STIFFNESS = 3'd2;
    localparam logic [2:0] REG_DAMPING   = 3'd3;
    localparam logic [2:0] REG_MS_PASS   = 3'd4;

    typedef enum logic [2:0] {
        OUT_SKIP      = 3'd0,
        OUT_NOCONTACT = 3'd1,
        OUT_RELEASED  = 3'd2,
        OUT_PASSED    = 3'd3,
        OUT_FORCE     = 3'd4
    } t_outcome;

    typedef enum logic [3:0] {
        MOP_SS, MOP_LHS, MOP_DD, MOP_RHS,
        MOP_N0, MOP_N1, MOP_N2,
        MOP_P0, MOP_P1, MOP_P2,
        MOP_FD, MOP_FS,
        MOP_F0, MOP_F1, MOP_F2
    } t_mop;

    typedef enum logic [1:0] {SH_0, SH_16, SH_24, SH_32} t_shift;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_ENT, S_DIV, S_DWAIT, S_MSTART, S_MWAIT, S_OUT
    } t_state;

    typedef struct packed {
        logic            latch_in;
        logic            clr;
        logic            tab_we;
        logic [ST_W-1:0] tab_st;
        logic            tab_held;
        logic            div_start;
        logic            mul_start;
        logic            mul_take;
        t_mop            mop;
        logic            load_out;
        t_outcome        outcome;
    } t_cmd;

    typedef struct packed {
        logic            clr_last;
        logic            skip;
        logic            barred;
        logic            no_contact;
        logic [ST_W-1:0] ent_st;
        logic            held_match;
        logic            d_pos;
        logic            pass_ok;
        logic            div_done;
        logic            mul_done;
        logic            out_free;
    } t_sts;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) return S64_MAX;
        if (a[63] && b[63] && !s[63]) return S64_MIN;
        return s;
    endfunction

endpackage

// ===== rtl/scf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module scf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/scf_mul.sv =====
// Shared signed multiply unit: 32x32 partial products, shift and saturation.
module scf_mul import scf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    input  t_shift             i_sh,
    output logic               o_done,
    output logic signed [63:0] o_res,
    output logic [127:0]       o_prod
);
    logic         r_busy, r_done, r_pv, r_neg;
    logic [2:0]   r_cnt;
    logic [1:0]   r_pidx;
    logic [63:0]  r_ma, r_mb, r_pp;
    logic [127:0] r_acc;
    t_shift       r_sh;

    logic [63:0]  ma, mb, pp_next, qlo, qhi;
    logic [31:0]  pa, pb;
    logic [127:0] pp_sh, q;

    assign ma = i_a[63] ? (~i_a + 64'd1) : i_a;
    assign mb = i_b[63] ? (~i_b + 64'd1) : i_b;

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin pa = r_ma[31:0];  pb = r_mb[31:0];  end
            2'd1: begin pa = r_ma[31:0];  pb = r_mb[63:32]; end
            2'd2: begin pa = r_ma[63:32]; pb = r_mb[31:0];  end
            default: begin pa = r_ma[63:32]; pb = r_mb[63:32]; end
        endcase
    end

    assign pp_next = pa * pb;

    always_comb begin
        case (r_pidx)
            2'd0:    pp_sh = {64'd0, r_pp};
            2'd3:    pp_sh = {r_pp, 64'd0};
            default: pp_sh = {32'd0, r_pp, 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pv   <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_pv   <= 1'b0;
                r_cnt  <= 3'd0;
                r_ma   <= ma;
                r_mb   <= mb;
                r_neg  <= i_a[63] ^ i_b[63];
                r_sh   <= i_sh;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_pv) begin
                    r_acc <= r_acc + pp_sh;
                end
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_pv   <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_pp   <= pp_next;
                    r_pidx <= r_cnt[1:0];
                    r_pv   <= 1'b1;
                    r_cnt  <= r_cnt + 3'd1;
                end
            end
        end
    end

    always_comb begin
        case (r_sh)
            SH_0:    q = r_acc;
            SH_16:   q = r_acc >> 16;
            SH_24:   q = r_acc >> 24;
            default: q = r_acc >> 32;
        endcase
    end

    assign qhi = q[127:64];
    assign qlo = q[63:0];

    always_comb begin
        if (r_neg) begin
            if (qhi != 64'd0 || qlo >= 64'h8000_0000_0000_0000) begin
                o_res = S64_MIN;
            end else begin
                o_res = ~qlo + 64'd1;
            end
        end else begin
            if (qhi != 64'd0 || qlo[63]) begin
                o_res = S64_MAX;
            end else begin
                o_res = qlo;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ===== rtl/scf_ctrl.sv =====
// Controller state machine: table clearing, contact decisions and operation sequencing.
module scf_ctrl import scf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_stall
);
    t_state   r_state, n_state;
    t_mop     r_mop, n_mop;
    t_outcome r_outc, n_outc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mop   <= MOP_SS;
            r_outc  <= OUT_SKIP;
        end else begin
            r_state <= n_state;
            r_mop   <= n_mop;
            r_outc  <= n_outc;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_mop         = r_mop;
        n_outc        = r_outc;
        o_cmd         = '0;
        o_cmd.mop     = r_mop;
        o_cmd.outcome = r_outc;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_RD: begin
                n_state = S_ENT;
            end
            S_ENT: begin
                if (i_sts.skip) begin
                    n_outc  = OUT_SKIP;
                    n_state = S_OUT;
                end else if (i_sts.no_contact) begin
                    if (i_sts.ent_st == ST_HELD && i_sts.held_match) begin
                        o_cmd.tab_we = 1'b1;
                        o_cmd.tab_st = ST_FREE;
                        n_outc       = OUT_RELEASED;
                    end else begin
                        n_outc = OUT_NOCONTACT;
                    end
                    n_state = S_OUT;
                end else if (i_sts.ent_st == ST_FREE) begin
                    if (!i_sts.barred && i_sts.d_pos) begin
                        n_mop   = MOP_SS;
                        n_state = S_MSTART;
                    end else begin
                        o_cmd.tab_we   = 1'b1;
                        o_cmd.tab_st   = ST_HELD;
                        o_cmd.tab_held = 1'b1;
                        n_state        = S_DIV;
                    end
                end else if (i_sts.ent_st == ST_HELD) begin
                    n_state = S_DIV;
                end else begin
                    n_outc  = OUT_PASSED;
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    n_mop   = MOP_N0;
                    n_state = S_MSTART;
                end
            end
            S_MSTART: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_take = 1'b1;
                    case (r_mop)
                        MOP_RHS: begin
                            o_cmd.tab_we = 1'b1;
                            if (i_sts.pass_ok) begin
                                o_cmd.tab_st = ST_PASSED;
                                n_outc       = OUT_PASSED;
                                n_state      = S_OUT;
                            end else begin
                                o_cmd.tab_st   = ST_HELD;
                                o_cmd.tab_held = 1'b1;
                                n_state        = S_DIV;
                            end
                        end
                        MOP_F2: begin
                            n_outc  = OUT_FORCE;
                            n_state = S_OUT;
                        end
                        default: begin
                            n_mop   = t_mop'(4'(r_mop) + 4'd1);
                            n_state = S_MSTART;
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
endmodule

// ===== rtl/scf_dp.sv =====
// Datapath: word capture, contact table, reciprocal divider, multiply unit and output register.
module scf_dp import scf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [15:0]        i_particle_index,
    input  logic [11:0]        i_triangle_index,
    input  logic signed [31:0] i_overlap,
    input  logic signed [31:0] i_delta_x,
    input  logic signed [31:0] i_delta_y,
    input  logic signed [31:0] i_delta_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic [30:0]        i_particle_radius,
    input  logic [15:0]        i_random_draw,
    input  logic [1:0]         i_particle_class,
    input  logic [30:0]        i_cfg_size,
    input  logic [30:0]        i_cfg_spacing,
    input  logic [33:0]        i_cfg_stiffness,
    input  logic [39:0]        i_cfg_damping,
    input  logic               i_cfg_ms_pass,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [63:0] o_force_x,
    output logic signed [63:0] o_force_y,
    output logic signed [63:0] o_force_z,
    output logic [2:0]         o_outcome
);
    logic [TAB_AW-1:0]  r_pidx;
    logic [TRI_W-1:0]   r_tri;
    logic signed [31:0] r_ov;
    logic signed [31:0] r_d [3];
    logic signed [31:0] r_v [3];
    logic [30:0]        r_rad;
    logic [15:0]        r_draw;
    logic [1:0]         r_cls;

    logic [TAB_AW-1:0]  r_clr;
    logic [ENT_W-1:0]   rdata, wdata;
    logic [TAB_AW-1:0]  waddr;
    logic               we;

    logic               r_dbusy, r_ddone;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [31:0]        r_rem, dtrial;
    logic [30:0]        r_dsr;
    logic [QUO_W-1:0]   r_quo;
    logic               dge;

    logic signed [63:0] r_tmp, r_vn, r_fn;
    logic [127:0]       r_lhs;
    logic signed [63:0] r_n [3];
    logic signed [63:0] r_f [3];

    logic signed [63:0] r_fo [3];
    logic               r_ovalid;
    t_outcome           r_outc;

    logic signed [63:0] ma, mb, mres, inv, dsz, negov, fsum;
    logic [127:0]       mprod;
    logic               mdone;
    t_shift             msh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_pidx <= i_particle_index[TAB_AW-1:0];
            r_tri  <= i_triangle_index;
            r_ov   <= i_overlap;
            r_d[0] <= i_delta_x;
            r_d[1] <= i_delta_y;
            r_d[2] <= i_delta_z;
            r_v[0] <= i_vel_x;
            r_v[1] <= i_vel_y;
            r_v[2] <= i_vel_z;
            r_rad  <= i_particle_radius;
            r_draw <= i_random_draw;
            r_cls  <= i_particle_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + TAB_AW'(1);
        end
    end

    assign we    = i_cmd.clr | i_cmd.tab_we;
    assign waddr = i_cmd.clr ? r_clr : r_pidx;
    assign wdata = i_cmd.clr ? '0 :
                   {i_cmd.tab_st, (i_cmd.tab_held ? r_tri : {TRI_W{1'b0}})};

    scf_ram #(.WIDTH(ENT_W), .DEPTH(NUM_PARTICLES)) u_tab (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_pidx),
        .o_rdata (rdata)
    );

    // reciprocal: floor(2^56 / r), one quotient bit a cycle
    assign dtrial = {r_rem[30:0], (r_dcnt == '0)};
    assign dge    = (dtrial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            r_ddone <= 1'b0;
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= '0;
                r_rem   <= '0;
                r_quo   <= '0;
                r_dsr   <= (r_rad == 31'd0) ? 31'd1 : r_rad;
            end else if (r_dbusy) begin
                r_rem  <= dge ? (dtrial - {1'b0, r_dsr}) : dtrial;
                r_quo  <= {r_quo[QUO_W-2:0], dge};
                r_dcnt <= r_dcnt + DCNT_W'(1);
                if (r_dcnt == DIV_LAST) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
        end
    end

    assign inv   = {{(64-QUO_W){1'b0}}, r_quo};
    assign dsz   = $signed({33'd0, i_cfg_size}) - $signed({32'd0, r_rad, 1'b0});
    assign negov = -{{32{r_ov[31]}}, r_ov};

    always_comb begin
        ma  = '0;
        mb  = '0;
        msh = SH_0;
        case (i_cmd.mop)
            MOP_SS:  begin ma = {33'd0, i_cfg_spacing}; mb = {33'd0, i_cfg_spacing}; end
            MOP_LHS: begin ma = r_tmp; mb = {32'd0, r_draw, 16'd0}; end
            MOP_DD:  begin ma = dsz; mb = dsz; end
            MOP_RHS: begin ma = r_tmp; mb = PIOVERFOUR; end
            MOP_N0:  begin ma = {{32{r_d[0][31]}}, r_d[0]}; mb = inv; msh = SH_32; end
            MOP_N1:  begin ma = {{32{r_d[1][31]}}, r_d[1]}; mb = inv; msh = SH_32; end
            MOP_N2:  begin ma = {{32{r_d[2][31]}}, r_d[2]}; mb = inv; msh = SH_32; end
            MOP_P0:  begin ma = {{32{r_v[0][31]}}, r_v[0]}; mb = r_n[0]; msh = SH_24; end
            MOP_P1:  begin ma = {{32{r_v[1][31]}}, r_v[1]}; mb = r_n[1]; msh = SH_24; end
            MOP_P2:  begin ma = {{32{r_v[2][31]}}, r_v[2]}; mb = r_n[2]; msh = SH_24; end
            MOP_FD:  begin ma = {24'd0, i_cfg_damping}; mb = r_vn; msh = SH_16; end
            MOP_FS:  begin ma = {30'd0, i_cfg_stiffness}; mb = negov; end
            MOP_F0:  begin ma = r_fn; mb = r_n[0]; msh = SH_24; end
            MOP_F1:  begin ma = r_fn; mb = r_n[1]; msh = SH_24; end
            MOP_F2:  begin ma = r_fn; mb = r_n[2]; msh = SH_24; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    scf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (ma),
        .i_b     (mb),
        .i_sh    (msh),
        .o_done  (mdone),
        .o_res   (mres),
        .o_prod  (mprod)
    );

    assign fsum = sat_add(r_fn, mres);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_take) begin
            case (i_cmd.mop)
                MOP_SS, MOP_DD: r_tmp <= mprod[63:0];
                MOP_LHS: r_lhs  <= mprod;
                MOP_N0:  r_n[0] <= mres;
                MOP_N1:  r_n[1] <= mres;
                MOP_N2:  r_n[2] <= mres;
                MOP_P0:  r_vn   <= mres;
                MOP_P1, MOP_P2: r_vn <= sat_add(r_vn, mres);
                MOP_FD:  r_fn   <= mres;
                MOP_FS:  r_fn   <= fsum[63] ? 64'sd0 : fsum;
                MOP_F0:  r_f[0] <= mres;
                MOP_F1:  r_f[1] <= mres;
                MOP_F2:  r_f[2] <= mres;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_outc  <= i_cmd.outcome;
            r_fo[0] <= (i_cmd.outcome == OUT_FORCE) ? r_f[0] : 64'sd0;
            r_fo[1] <= (i_cmd.outcome == OUT_FORCE) ? r_f[1] : 64'sd0;
            r_fo[2] <= (i_cmd.outcome == OUT_FORCE) ? r_f[2] : 64'sd0;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.clr_last   = &r_clr;
        o_sts.skip       = r_cls[1];
        o_sts.barred     = (r_cls == 2'd1) && !i_cfg_ms_pass;
        o_sts.no_contact = !r_ov[31] && (r_ov != 32'sd0);
        o_sts.ent_st     = rdata[ENT_W-1:TRI_W];
        o_sts.held_match = (rdata[TRI_W-1:0] == r_tri);
        o_sts.d_pos      = !dsz[63] && (dsz != 64'sd0);
        o_sts.pass_ok    = (r_lhs < mprod);
        o_sts.div_done   = r_ddone;
        o_sts.mul_done   = mdone;
        o_sts.out_free   = !r_ovalid || !i_stall;
    end

    assign o_valid   = r_ovalid;
    assign o_force_x = r_fo[0];
    assign o_force_y = r_fo[1];
    assign o_force_z = r_fo[2];
    assign o_outcome = r_outc;
endmodule

// ===== rtl/sieve_contact_force.sv =====
// Top level of the sieve contact force block: register file, controller and datapath.
// After reset the block clears its 65536-entry contact table, one entry a cycle, and
// holds o_stall high until the table is clear; register writes are taken meanwhile.
// Each word is then handled alone. Skipped, no-contact, released and already-passed
// words pass through the table read and the decision before their result is loaded
// into the output register and the input is freed. A held particle first takes the
// reciprocal of the radius (one quotient bit a cycle plus start and finish), then
// eleven products on one shared 32x32 multiplier. A free particle that takes the pass
// test needs four more products for it. A new word is accepted while a finished
// result still waits in the output register.
module sieve_contact_force import scf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [15:0]           i_particle_index,
    input  logic [11:0]           i_triangle_index,
    input  logic signed [31:0]    i_overlap,
    input  logic signed [31:0]    i_delta_x,
    input  logic signed [31:0]    i_delta_y,
    input  logic signed [31:0]    i_delta_z,
    input  logic signed [31:0]    i_vel_x,
    input  logic signed [31:0]    i_vel_y,
    input  logic signed [31:0]    i_vel_z,
    input  logic [30:0]           i_particle_radius,
    input  logic [15:0]           i_random_draw,
    input  logic [1:0]            i_particle_class,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [63:0]    o_force_x,
    output logic signed [63:0]    o_force_y,
    output logic signed [63:0]    o_force_z,
    output logic [2:0]            o_outcome,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);
    logic [30:0] r_size, r_spacing;
    logic [33:0] r_stiff;
    logic [39:0] r_damp;
    logic        r_mspass;
    logic        wr;
    t_cmd        cmd;
    t_sts        sts;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= '0;
            r_spacing <= 31'd16777216;
            r_stiff   <= '0;
            r_damp    <= '0;
            r_mspass  <= 1'b0;
        end else if (wr) begin
            case (paddr[5:3])
                REG_SIZE:      r_size    <= pwdata[30:0];
                REG_SPACING:   r_spacing <= pwdata[30:0];
                REG_STIFFNESS: r_stiff   <= pwdata[33:0];
                REG_DAMPING:   r_damp    <= pwdata[39:0];
                REG_MS_PASS:   r_mspass  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_SIZE:      prdata = {33'd0, r_size};
            REG_SPACING:   prdata = {33'd0, r_spacing};
            REG_STIFFNESS: prdata = {30'd0, r_stiff};
            REG_DAMPING:   prdata = {24'd0, r_damp};
            REG_MS_PASS:   prdata = {63'd0, r_mspass};
            default:       prdata = '0;
        endcase
    end

    scf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    scf_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_particle_index  (i_particle_index),
        .i_triangle_index  (i_triangle_index),
        .i_overlap         (i_overlap),
        .i_delta_x         (i_delta_x),
        .i_delta_y         (i_delta_y),
        .i_delta_z         (i_delta_z),
        .i_vel_x           (i_vel_x),
        .i_vel_y           (i_vel_y),
        .i_vel_z           (i_vel_z),
        .i_particle_radius (i_particle_radius),
        .i_random_draw     (i_random_draw),
        .i_particle_class  (i_particle_class),
        .i_cfg_size        (r_size),
        .i_cfg_spacing     (r_spacing),
        .i_cfg_stiffness   (r_stiff),
        .i_cfg_damping     (r_damp),
        .i_cfg_ms_pass     (r_mspass),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_force_x         (o_force_x),
        .o_force_y         (o_force_y),
        .o_force_z         (o_force_z),
        .o_outcome         (o_outcome)
    );
endmodule

// ===== rtl/scf_checker.sv =====
// Port-level checker of the sieve contact force block and its bind.
`include "sieve_contact_force_macros.svh"
module scf_checker import scf_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [63:0] o_force_x,
    input logic signed [63:0] o_force_y,
    input logic signed [63:0] o_force_z,
    input logic [2:0]         o_outcome
);
    `SCF_ASSERT_IMP(a_no_force_zero, o_valid && (o_outcome != OUT_FORCE), (o_force_x == 64'sd0) && (o_force_y == 64'sd0) && (o_force_z == 64'sd0), "forces nonzero without force outcome")
    `SCF_ASSERT_IMP(a_outcome_range, o_valid, o_outcome <= OUT_FORCE, "outcome code out of range")
    `SCF_ASSERT_NXT(a_busy_after_take, i_valid && !o_stall, o_stall, "second word taken while busy")
    `SCF_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_outcome) && $stable(o_force_x), "stalled word changed")
endmodule

bind sieve_contact_force scf_checker u_scf_checker (.*);
